### design/quoted_command_tokenizer_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef QUOTED_COMMAND_TOKENIZER_MACROS_SVH
`define QUOTED_COMMAND_TOKENIZER_MACROS_SVH

// Same-cycle implication, clocked on aclk, disabled while in reset.
`define QCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, disabled while in reset.
`define QCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/qct_pkg.sv
// Types, character codes and helpers for the quoted command tokenizer.
package qct_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_MALFORMED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_BODY  = 2'd1,
        PH_AFTER = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   wrapped;
        logic   in_quotes;
        logic   token_open;
        logic   escape_pending;
        logic   malformed;
        logic   any_token;
    } tok_state_t;

    localparam tok_state_t TOK_STATE_RESET = '{
        phase: PH_LEAD, wrapped: 1'b0, in_quotes: 1'b0, token_open: 1'b0,
        escape_pending: 1'b0, malformed: 1'b0, any_token: 1'b0
    };

    typedef struct packed {
        kind_t      kind;
        logic [7:0] token_byte;
        status_t    status;
        logic       last;
    } result_t;

    // C-locale whitespace: tab, newline, vertical tab, form feed, carriage return, space
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic result_t mk_res(input kind_t k, input logic [7:0] b, input status_t s);
        result_t r;
        r.kind       = k;
        r.token_byte = b;
        r.status     = s;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

### design/quoted_command_tokenizer.sv
// Quoted command tokenizer: splits a byte stream into tokens and a final status.
// The block takes one command byte per transaction on the slave side, the command
// closed by a transaction with s_tlast high (its byte is ignored). It splits the
// text at unquoted whitespace; double quotes toggle quoting, and inside quotes a
// backslash escapes a quote or a backslash. A command that opens with '(' must be
// closed by a matching unquoted ')' followed only by whitespace. The master side
// gives token bytes (m_tuser = 0), token ends (m_tuser = 1) and one finish
// transaction (m_tuser = 2) carrying the status: 0 ok with tokens, 1 ok but
// empty, 2 malformed. m_tlast marks the final result caused by one input byte.
// Bytes already given out before an error are not withdrawn. Rate: one input
// transaction per cycle while the result queue has room for two results. An item
// makes zero, one or two results; the single result port drains one per cycle
// while m_tready is high, so a run of two-result items (token end before finish,
// a held backslash before the next byte) paces input to the result port through
// a four-entry result queue. No clearing pass after reset.
module quoted_command_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // end_of_command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] token_byte, [9:8] status, [15:10] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last
);

    `include "quoted_command_tokenizer_macros.svh"

    // Input register
    logic                    in_valid_reg;
    logic [7:0]              in_data_reg;
    logic                    in_last_reg;

    // Tokenizer state
    qct_pkg::tok_state_t     st_reg;
    qct_pkg::tok_state_t     st_next;

    // Results of the item in the input register
    qct_pkg::result_t        res [2];
    logic [1:0]              n_res;
    logic                    body_go;
    logic                    esc_done;
    logic                    end_bad;

    // Result queue
    qct_pkg::result_t        fifo_reg [qct_pkg::FIFO_DEPTH];
    logic [qct_pkg::PTR_W-1:0] wr_ptr_reg;
    logic [qct_pkg::PTR_W-1:0] wr_ptr_p1;
    logic [qct_pkg::PTR_W-1:0] rd_ptr_reg;
    logic [qct_pkg::CNT_W-1:0] count_reg;
    logic [qct_pkg::CNT_W-1:0] count_next;
    qct_pkg::result_t        head;

    logic proc_fire;
    logic pop;

    // Process an item only when the queue can take the worst case of two results
    assign proc_fire = in_valid_reg &&
                       (count_reg <= qct_pkg::CNT_W'(qct_pkg::FIFO_DEPTH - 2));
    assign s_tready  = !in_valid_reg || proc_fire;
    assign pop       = m_tvalid && m_tready;
    assign wr_ptr_p1 = wr_ptr_reg + qct_pkg::PTR_W'(1);

    // One tokenizer step for the held byte
    always_comb begin
        st_next  = st_reg;
        res[0]   = qct_pkg::mk_res(qct_pkg::KIND_BYTE, 8'h00, qct_pkg::STAT_OK);
        res[1]   = qct_pkg::mk_res(qct_pkg::KIND_BYTE, 8'h00, qct_pkg::STAT_OK);
        n_res    = 2'd0;
        body_go  = 1'b0;
        esc_done = 1'b0;
        end_bad  = 1'b0;

        if (in_last_reg) begin
            end_bad = st_reg.malformed || st_reg.in_quotes ||
                      (st_reg.wrapped && (st_reg.phase != qct_pkg::PH_AFTER));
            if (end_bad) begin
                res[0] = qct_pkg::mk_res(qct_pkg::KIND_DONE, 8'h00,
                                         qct_pkg::STAT_MALFORMED);
                n_res  = 2'd1;
            end else begin
                // close an open token before the finish
                if (st_reg.token_open) begin
                    res[n_res[0]] = qct_pkg::mk_res(qct_pkg::KIND_END, 8'h00,
                                                    qct_pkg::STAT_OK);
                    n_res = n_res + 2'd1;
                end
                res[n_res[0]] = qct_pkg::mk_res(qct_pkg::KIND_DONE, 8'h00,
                    (st_reg.any_token || st_reg.token_open) ? qct_pkg::STAT_OK
                                                            : qct_pkg::STAT_EMPTY);
                n_res = n_res + 2'd1;
            end
            st_next = qct_pkg::TOK_STATE_RESET;
        end else if (!st_reg.malformed) begin
            unique case (st_reg.phase)
                qct_pkg::PH_LEAD: begin
                    if (!qct_pkg::is_space(in_data_reg)) begin
                        st_next.phase = qct_pkg::PH_BODY;
                        if (in_data_reg == qct_pkg::CH_LPAREN) begin
                            st_next.wrapped = 1'b1;
                        end else begin
                            body_go = 1'b1;
                        end
                    end
                end
                qct_pkg::PH_BODY: begin
                    body_go = 1'b1;
                end
                qct_pkg::PH_AFTER: begin
                    if (!qct_pkg::is_space(in_data_reg)) begin
                        st_next.malformed = 1'b1;
                    end
                end
                default: begin
                    st_next.malformed = 1'b1;
                end
            endcase

            if (body_go) begin
                // resolve a held backslash first
                if (st_reg.escape_pending) begin
                    st_next.escape_pending = 1'b0;
                    if ((in_data_reg == qct_pkg::CH_QUOTE) ||
                        (in_data_reg == qct_pkg::CH_BSLASH)) begin
                        res[0]   = qct_pkg::mk_res(qct_pkg::KIND_BYTE, in_data_reg,
                                                   qct_pkg::STAT_OK);
                        esc_done = 1'b1;
                    end else begin
                        res[0] = qct_pkg::mk_res(qct_pkg::KIND_BYTE, qct_pkg::CH_BSLASH,
                                                 qct_pkg::STAT_OK);
                    end
                    n_res = 2'd1;
                end

                if (!esc_done) begin
                    priority if (in_data_reg == qct_pkg::CH_NUL) begin
                        st_next.malformed = 1'b1;
                    end else if (st_reg.in_quotes &&
                                 (in_data_reg == qct_pkg::CH_BSLASH)) begin
                        st_next.escape_pending = 1'b1;
                    end else if (in_data_reg == qct_pkg::CH_QUOTE) begin
                        st_next.in_quotes  = !st_reg.in_quotes;
                        st_next.token_open = 1'b1;
                    end else if (!st_reg.in_quotes &&
                                 ((in_data_reg == qct_pkg::CH_LPAREN) ||
                                  (in_data_reg == qct_pkg::CH_RPAREN))) begin
                        if ((in_data_reg == qct_pkg::CH_RPAREN) && st_reg.wrapped) begin
                            if (st_reg.token_open) begin
                                res[n_res[0]] = qct_pkg::mk_res(qct_pkg::KIND_END,
                                                    8'h00, qct_pkg::STAT_OK);
                                n_res = n_res + 2'd1;
                                st_next.token_open = 1'b0;
                                st_next.any_token  = 1'b1;
                            end
                            st_next.phase = qct_pkg::PH_AFTER;
                        end else begin
                            st_next.malformed = 1'b1;
                        end
                    end else if (!st_reg.in_quotes && qct_pkg::is_space(in_data_reg)) begin
                        if (st_reg.token_open) begin
                            res[n_res[0]] = qct_pkg::mk_res(qct_pkg::KIND_END, 8'h00,
                                                            qct_pkg::STAT_OK);
                            n_res = n_res + 2'd1;
                            st_next.token_open = 1'b0;
                            st_next.any_token  = 1'b1;
                        end
                    end else begin
                        res[n_res[0]] = qct_pkg::mk_res(qct_pkg::KIND_BYTE, in_data_reg,
                                                        qct_pkg::STAT_OK);
                        n_res = n_res + 2'd1;
                        st_next.token_open = 1'b1;
                    end
                end
            end
        end

        // flag the final result of this item
        if (n_res == 2'd1) begin
            res[0].last = 1'b1;
        end else if (n_res == 2'd2) begin
            res[1].last = 1'b1;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (proc_fire) begin
            count_next = count_next + qct_pkg::CNT_W'(n_res);
        end
        if (pop) begin
            count_next = count_next - qct_pkg::CNT_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            st_reg       <= qct_pkg::TOK_STATE_RESET;
            count_reg    <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (proc_fire) begin
                st_reg     <= st_next;
                wr_ptr_reg <= wr_ptr_reg + qct_pkg::PTR_W'(n_res);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + qct_pkg::PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Payload registers: hold the input byte, write results into the queue
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proc_fire && (n_res != 2'd0)) begin
            fifo_reg[wr_ptr_reg] <= res[0];
        end
        if (proc_fire && (n_res == 2'd2)) begin
            fifo_reg[wr_ptr_p1] <= res[1];
        end
    end

    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {6'b000000, head.status, head.token_byte};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

    // Checks
    `QCT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= qct_pkg::CNT_W'(qct_pkg::FIFO_DEPTH), "result queue overflow")
    `QCT_ASSERT_NOW(a_room_on_fire, proc_fire, count_reg <= qct_pkg::CNT_W'(qct_pkg::FIFO_DEPTH - 2), "item processed without room for two results")
    `QCT_ASSERT_NEXT(a_reset_after_end, proc_fire && in_last_reg, st_reg == qct_pkg::TOK_STATE_RESET, "state not cleared after command end")
    `QCT_ASSERT_NOW(a_silent_malformed, proc_fire && st_reg.malformed && !in_last_reg, n_res == 2'd0, "result from a malformed command before its end")

endmodule

### tb/qct_stream_checker.sv
// Stream checker for the quoted command tokenizer: predicts results and compares them.
`timescale 1ns / 1ps

module qct_stream_checker
    import qct_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding
);

    // Tokenizer state as this checker tracks it
    phase_t ph;
    logic   wrapped;
    logic   quoted;
    logic   tok_open;
    logic   bs_held;
    logic   broken;
    logic   got_token;

    result_t step_results[$];
    result_t pending_tokens[$];

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    task automatic clear_state();
        ph        = PH_LEAD;
        wrapped   = 1'b0;
        quoted    = 1'b0;
        tok_open  = 1'b0;
        bs_held   = 1'b0;
        broken    = 1'b0;
        got_token = 1'b0;
    endtask

    task automatic add_result(input kind_t k, input logic [7:0] b, input status_t s);
        result_t r;
        r.kind       = k;
        r.token_byte = b;
        r.status     = s;
        r.last       = 1'b0;
        step_results.insert(step_results.size(), r);
    endtask

    task automatic end_token();
        if (tok_open) begin
            add_result(KIND_END, 8'h00, STAT_OK);
            tok_open  = 1'b0;
            got_token = 1'b1;
        end
    endtask

    task automatic take_body_byte(input logic [7:0] c);
        // a held backslash is resolved by the byte that follows it
        if (bs_held) begin
            bs_held = 1'b0;
            if (c == CH_QUOTE || c == CH_BSLASH) begin
                add_result(KIND_BYTE, c, STAT_OK);
                return;
            end
            add_result(KIND_BYTE, CH_BSLASH, STAT_OK);
        end
        if (c == CH_NUL) begin
            broken = 1'b1;
            return;
        end
        if (quoted && c == CH_BSLASH) begin
            bs_held = 1'b1;
            return;
        end
        if (c == CH_QUOTE) begin
            quoted   = !quoted;
            tok_open = 1'b1;
            return;
        end
        if (!quoted && (c == CH_LPAREN || c == CH_RPAREN)) begin
            if (c == CH_RPAREN && wrapped) begin
                end_token();
                ph = PH_AFTER;
            end else begin
                broken = 1'b1;
            end
            return;
        end
        if (!quoted && is_blank(c)) begin
            end_token();
            return;
        end
        add_result(KIND_BYTE, c, STAT_OK);
        tok_open = 1'b1;
    endtask

    task automatic tokenize_step(input logic [7:0] c, input logic eoc);
        step_results.delete();
        if (eoc) begin
            if (!broken && (quoted || (wrapped && ph != PH_AFTER)))
                broken = 1'b1;
            if (broken) begin
                add_result(KIND_DONE, 8'h00, STAT_MALFORMED);
            end else begin
                end_token();
                add_result(KIND_DONE, 8'h00, got_token ? STAT_OK : STAT_EMPTY);
            end
            clear_state();
        end else if (!broken) begin
            case (ph)
                PH_LEAD: begin
                    if (!is_blank(c)) begin
                        ph = PH_BODY;
                        if (c == CH_LPAREN)
                            wrapped = 1'b1;
                        else
                            take_body_byte(c);
                    end
                end
                PH_BODY: begin
                    take_body_byte(c);
                end
                default: begin
                    if (!is_blank(c))
                        broken = 1'b1;
                end
            endcase
        end
        if (step_results.size() != 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            pending_tokens.insert(pending_tokens.size(), step_results[i]);
    endtask

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_result();
        result_t want;
        if (pending_tokens.size() == 0) begin
            report($sformatf("unexpected result kind %0d data %0h", m_tuser, m_tdata));
            return;
        end
        want = pending_tokens.pop_front();
        if (m_tuser != want.kind)
            report($sformatf("kind: want %0d got %0d", want.kind, m_tuser));
        if (m_tdata[7:0] != want.token_byte)
            report($sformatf("token byte: want %02h got %02h", want.token_byte, m_tdata[7:0]));
        if (m_tdata[9:8] != want.status)
            report($sformatf("status: want %0d got %0d", want.status, m_tdata[9:8]));
        if (m_tdata[15:10] != 6'd0)
            report($sformatf("padding bits not zero: %02h", m_tdata[15:10]));
        if (m_tlast != want.last)
            report($sformatf("last: want %0b got %0b", want.last, m_tlast));
    endtask

    // Results are matched before the input of the same edge is predicted
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            pending_tokens.delete();
            mismatches = 0;
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                tokenize_step(s_tdata, s_tlast);
        end
        outstanding <= pending_tokens.size();
    end

endmodule

### tb/tb_quoted_command_tokenizer.sv
// Testbench top for the quoted command tokenizer: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_quoted_command_tokenizer;
    import qct_pkg::*;

    localparam int ITEM_TARGET = 1850;
    // slowest run: ~2000 items, each with the longest gap and two results behind
    // the longest stalls, stays well under CYCLE_LIMIT
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int mismatches;
    int outstanding;
    int items_sent = 0;
    int cycles     = 0;
    bit steady     = 1'b0;   // when set, neither side idles

    logic [7:0] line_q[$];   // bytes of the command being built

    quoted_command_tokenizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    qct_stream_checker tokens_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Guard against a hung handshake
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: stall for a random number of cycles, then hold tready until a
    // transaction goes through. Only one assignment to m_tready per edge.
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Present one transaction, after a random gap, and hold it until accepted.
    // tvalid is only lowered when a gap follows, so back-to-back items keep it high.
    task automatic send_item(input logic [7:0] b, input logic eoc);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eoc;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Append one byte to the line being built
    task automatic line_add(input logic [7:0] c);
        line_q.insert(line_q.size(), c);
    endtask

    // Send the built line, then the end marker carrying a throwaway byte
    task automatic send_line(input logic [7:0] end_byte);
        foreach (line_q[i])
            send_item(line_q[i], 1'b0);
        send_item(end_byte, 1'b1);
        line_q.delete();
    endtask

    task automatic queue_text(input string text);
        for (int i = 0; i < text.len(); i++)
            line_add(text[i]);
    endtask

    // Hold off the sender until every predicted result has been seen
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    function automatic logic [7:0] blank_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 5));
        return (c == 8'd5) ? CH_SPACE : CH_TAB + c;
    endfunction

    // Any byte that stands for itself outside quotes
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || c == CH_QUOTE ||
                   c == CH_LPAREN || c == CH_RPAREN);
        return c;
    endfunction

    // Any byte that stands for itself inside quotes
    function automatic logic [7:0] quoted_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    task automatic add_blanks(input int n);
        repeat (n) line_add(blank_char());
    endtask

    task automatic add_plain(input int n);
        repeat (n) line_add(plain_char());
    endtask

    // Quoted segment with escaped quotes, escaped backslashes and literal backslashes
    task automatic add_quoted(input int n);
        line_add(CH_QUOTE);
        repeat (n) begin
            case ($urandom_range(0, 5))
                0: begin
                    line_add(CH_BSLASH);
                    line_add(CH_QUOTE);
                end
                1: begin
                    line_add(CH_BSLASH);
                    line_add(CH_BSLASH);
                end
                2: begin
                    line_add(CH_BSLASH);
                    line_add(quoted_char());
                end
                default: begin
                    line_add(quoted_char());
                end
            endcase
        end
        line_add(CH_QUOTE);
    endtask

    // Well-formed line with random content, optionally wrapped in parens
    task automatic build_wellformed();
        bit wrap;
        int ntok;
        wrap = ($urandom_range(0, 2) == 0);
        ntok = $urandom_range(0, 4);
        if ($urandom_range(0, 2) == 0)
            add_blanks($urandom_range(1, 3));
        if (wrap) begin
            line_add(CH_LPAREN);
            if ($urandom_range(0, 1) == 0)
                add_blanks($urandom_range(1, 2));
        end
        for (int k = 0; k < ntok; k++) begin
            if (k != 0)
                add_blanks($urandom_range(1, 3));
            case ($urandom_range(0, 2))
                0: add_plain($urandom_range(1, 5));
                1: add_quoted($urandom_range(0, 4));
                default: begin
                    add_plain($urandom_range(1, 3));
                    add_quoted($urandom_range(0, 3));
                end
            endcase
        end
        if (wrap)
            line_add(CH_RPAREN);
        if ($urandom_range(0, 2) == 0)
            add_blanks($urandom_range(1, 2));
    endtask

    // Break a built line: cut its tail, or drop in a NUL, a stray paren or any byte
    task automatic break_line();
        int pos;
        pos = $urandom_range(0, line_q.size());
        case ($urandom_range(0, 3))
            0: begin
                if (line_q.size() != 0)
                    void'(line_q.pop_back());
            end
            1: line_q.insert(pos, CH_NUL);
            2: line_q.insert(pos, $urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
            default: line_q.insert(pos, 8'($urandom_range(0, 255)));
        endcase
    endtask

    // Noise weighted towards the bytes the tokenizer treats specially
    task automatic build_noise();
        logic [7:0] specials[5];
        specials = '{CH_QUOTE, CH_BSLASH, CH_LPAREN, CH_RPAREN, CH_NUL};
        repeat ($urandom_range(0, 12)) begin
            case ($urandom_range(0, 3))
                0: line_add(blank_char());
                1: line_add(specials[$urandom_range(0, 4)]);
                default: line_add(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        int random_base;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part
        send_line(8'hFF);                 // empty line, end byte ignored
        queue_text("\"\"");               // empty quoted token still counts
        send_line(8'h00);
        queue_text("\"\\\"\\x\\");        // escaped quote, literal backslash, held backslash
        line_add(CH_NUL);                 // NUL releases the held backslash, then breaks
        send_line(8'h5A);
        queue_text("(a)b");               // text after the closing paren; 'a' stands
        send_line(8'hA5);
        line_add(8'hFF);                  // top byte as token byte, then stray ')'
        line_add(CH_RPAREN);
        send_line(8'h01);
        queue_text("a(");                 // stray '(' after the start
        send_line(8'h80);
        queue_text("(x");                 // wrapped and never closed
        send_line(8'h7F);
        queue_text("\"a");                // quote left open at the end
        send_line(8'hFE);
        wait_drained();

        // Random part, in three phases; the middle one runs without idling
        random_base = items_sent;
        for (int p = 0; p < 3; p++) begin
            while (items_sent - random_base < (ITEM_TARGET * (p + 1)) / 3) begin
                steady = (p == 1) || ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 3) != 0) begin
                    build_wellformed();
                    if ($urandom_range(0, 5) == 0)
                        break_line();
                end else begin
                    build_noise();
                end
                send_line(8'($urandom_range(0, 255)));
            end
            steady = 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/qct_pkg.sv
design/quoted_command_tokenizer.sv
tb/qct_stream_checker.sv
tb/tb_quoted_command_tokenizer.sv
